### hdl/ttg_pkg.sv
// shared types, constants and sequencer states for the triangle tangent generator
package ttg_pkg;

  // default number of fraction bits in the tangent words
  localparam int TANGENT_FRAC_BITS_DEF = 30;

  // corner slot carried by the third copy of a tangent
  localparam logic [1:0] LAST_SLOT = 2'd2;

  // corner count value at which the incoming vertex closes the triangle
  localparam logic [1:0] CLOSING_CORNER = 2'd2;

  // edge and uv deltas of one triangle, each 33 bits signed
  typedef struct packed {
    logic signed [32:0] dp1_x;
    logic signed [32:0] dp1_y;
    logic signed [32:0] dp1_z;
    logic signed [32:0] dp2_x;
    logic signed [32:0] dp2_y;
    logic signed [32:0] dp2_z;
    logic signed [32:0] du1;
    logic signed [32:0] dv1;
    logic signed [32:0] du2;
    logic signed [32:0] dv2;
  } delta_t;

  // one finished tangent with its flags
  typedef struct packed {
    logic signed [31:0] tangent_x;
    logic signed [31:0] tangent_y;
    logic signed [31:0] tangent_z;
    logic               uv_degenerate;
    logic               zero_tangent;
  } result_t;

  // sequencer states of the shared arithmetic unit
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_NORM,
    ST_SQ,
    ST_SQACC,
    ST_SQRT,
    ST_DINIT,
    ST_DIV,
    ST_DONE
  } ttg_state_t;

endpackage

### hdl/ttg_core.sv
// shared multiplier, square root and divider under one sequencer
module ttg_core #(
  parameter int TANGENT_FRAC_BITS = ttg_pkg::TANGENT_FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  ttg_pkg::delta_t  delta,
  output logic             res_valid,
  output ttg_pkg::result_t res
);
  import ttg_pkg::*;

  localparam int QW    = TANGENT_FRAC_BITS + 1;
  localparam int CNT_W = $clog2(TANGENT_FRAC_BITS + 1);

  ttg_state_t state_r, state_nxt;

  delta_t             dl_r;
  logic [2:0]         idx_r;
  logic signed [65:0] prod_r;
  logic signed [65:0] first_r;
  logic               det_neg_r;
  logic               degen_r;
  logic               zero_r;
  logic [65:0]        mag_r [3];
  logic               neg_r [3];
  logic [63:0]        sum_r;
  logic [63:0]        x_r;
  logic [63:0]        root_r;
  logic [63:0]        bit_r;
  logic [31:0]        len_r;
  logic [33:0]        rem_r;
  logic [QW-1:0]      q_r;
  logic [CNT_W-1:0]   cnt_r;
  logic signed [31:0] res_r [3];

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [66:0] diff;
  logic [66:0]        diff_abs;
  logic [65:0]        mag_or;
  logic               all_zero;
  logic               too_wide;
  logic [30:0]        m_sel;
  logic [63:0]        trial;
  logic               sq_ge;
  logic               div_ge;
  logic [33:0]        rem_sub;
  logic [QW-1:0]      q_nxt;
  logic [31:0]        q_ext;
  logic               div_last;

  // operand selection for the shared multiplier
  assign m_sel = mag_r[idx_r[1:0]][30:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == ST_SQ) begin
      mul_a = {2'b00, m_sel};
      mul_b = {2'b00, m_sel};
    end else begin
      unique case (idx_r)
        3'd0: begin mul_a = dl_r.du1;   mul_b = dl_r.dv2; end
        3'd1: begin mul_a = dl_r.dv1;   mul_b = dl_r.du2; end
        3'd2: begin mul_a = dl_r.dp1_x; mul_b = dl_r.dv2; end
        3'd3: begin mul_a = dl_r.dp2_x; mul_b = dl_r.dv1; end
        3'd4: begin mul_a = dl_r.dp1_y; mul_b = dl_r.dv2; end
        3'd5: begin mul_a = dl_r.dp2_y; mul_b = dl_r.dv1; end
        3'd6: begin mul_a = dl_r.dp1_z; mul_b = dl_r.dv2; end
        default: begin mul_a = dl_r.dp2_z; mul_b = dl_r.dv1; end
      endcase
    end
  end

  assign mul_p = mul_a * mul_b;

  // product difference and its magnitude
  assign diff     = {first_r[65], first_r} - {prod_r[65], prod_r};
  assign diff_abs = diff[66] ? (67'd0 - diff) : diff;

  // normalisation checks
  assign mag_or   = mag_r[0] | mag_r[1] | mag_r[2];
  assign all_zero = (mag_or == '0);
  assign too_wide = (mag_or[65:31] != '0);

  // square root step
  assign trial = root_r + bit_r;
  assign sq_ge = (x_r >= trial);

  // division step
  assign div_ge   = (rem_r >= {2'b00, len_r});
  assign rem_sub  = div_ge ? (rem_r - {2'b00, len_r}) : rem_r;
  assign q_nxt    = {q_r[QW-2:0], div_ge};
  assign q_ext    = 32'(q_nxt);
  assign div_last = (cnt_r == CNT_W'(TANGENT_FRAC_BITS));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_ACC;
      ST_ACC:   state_nxt = (idx_r == 3'd7) ? ST_NORM : ST_MUL;
      ST_NORM: begin
        priority if (all_zero) state_nxt = ST_DONE;
        else if (too_wide)     state_nxt = ST_NORM;
        else                   state_nxt = ST_SQ;
      end
      ST_SQ:    state_nxt = ST_SQACC;
      ST_SQACC: state_nxt = (idx_r[1:0] == 2'd2) ? ST_SQRT : ST_SQ;
      ST_SQRT:  if (bit_r[0]) state_nxt = ST_DINIT;
      ST_DINIT: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_last) state_nxt = (idx_r[1:0] == 2'd2) ? ST_DONE : ST_DINIT;
      end
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    res_valid         = (state_r == ST_DONE);
    res.tangent_x     = res_r[0];
    res.tangent_y     = res_r[1];
    res.tangent_z     = res_r[2];
    res.uv_degenerate = degen_r;
    res.zero_tangent  = zero_r;
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          dl_r  <= delta;
          idx_r <= '0;
        end
      end
      ST_ACC: begin
        if (!idx_r[0]) begin
          first_r <= prod_r;
        end else if (idx_r == 3'd1) begin
          det_neg_r <= diff[66];
          degen_r   <= (diff == '0);
        end else begin
          mag_r[idx_r[2:1] - 2'd1] <= diff_abs[65:0];
          neg_r[idx_r[2:1] - 2'd1] <= diff[66] ^ det_neg_r;
        end
        idx_r <= idx_r + 3'd1;
      end
      ST_NORM: begin
        zero_r <= all_zero;
        idx_r  <= '0;
        sum_r  <= '0;
        if (all_zero) begin
          res_r[0] <= '0;
          res_r[1] <= '0;
          res_r[2] <= '0;
        end else if (too_wide) begin
          mag_r[0] <= mag_r[0] >> 1;
          mag_r[1] <= mag_r[1] >> 1;
          mag_r[2] <= mag_r[2] >> 1;
        end
      end
      ST_SQACC: begin
        sum_r <= sum_r + 64'(unsigned'(prod_r[61:0]));
        x_r   <= sum_r + 64'(unsigned'(prod_r[61:0]));
        root_r <= '0;
        bit_r  <= 64'd1 << 62;
        idx_r  <= (idx_r[1:0] == 2'd2) ? 3'd0 : idx_r + 3'd1;
      end
      ST_SQRT: begin
        if (sq_ge) begin
          x_r    <= x_r - trial;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      ST_DINIT: begin
        len_r <= (root_r == '0) ? 32'd1 : root_r[31:0];
        rem_r <= {3'b000, m_sel};
        q_r   <= '0;
        cnt_r <= '0;
      end
      ST_DIV: begin
        rem_r <= {rem_sub[32:0], 1'b0};
        q_r   <= q_nxt;
        cnt_r <= cnt_r + CNT_W'(1);
        if (div_last) begin
          res_r[idx_r[1:0]] <= neg_r[idx_r[1:0]] ? (32'd0 - q_ext) : q_ext;
          idx_r <= idx_r + 3'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // normalised magnitudes fit the squaring operands
  a_norm_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQ) |-> (mag_or[65:31] == '0))
    else $error("magnitude too wide for squaring");

  // divisor is never zero while dividing
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (len_r != '0))
    else $error("zero divisor");

  // partial remainder stays below twice the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < ({2'b00, len_r} << 1)))
    else $error("remainder out of range");

  // a zero tangent gives a zero vector
  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && zero_r) |-> (res_r[0] == '0 && res_r[1] == '0 && res_r[2] == '0))
    else $error("zero tangent with non-zero output");

endmodule

### hdl/triangle_tangent_generator.sv
// top level: corner holding, delta forming and three-copy result stage
// latency: first and second corners are taken with no word out; the third corner starts the core,
// which runs the products, any normalising shifts, the square root and three divisions before
// the first word, then one word a cycle for three words while out_stall is low
// throughput: one triangle at a time; in_stall holds new corners until the last word is taken
// reset: synchronous active low, clears the corner count, busy flag, sequencer, slot and output valid
module triangle_tangent_generator #(
  parameter int TANGENT_FRAC_BITS = ttg_pkg::TANGENT_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_tex_u,
  input  logic signed [31:0] in_tex_v,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_tangent_x,
  output logic signed [31:0] out_tangent_y,
  output logic signed [31:0] out_tangent_z,
  output logic [1:0]         out_corner_slot,
  output logic               out_last_of_triangle,
  output logic               out_uv_degenerate,
  output logic               out_zero_tangent
);
  import ttg_pkg::*;

  logic [1:0]         corner_cnt_r;
  logic               busy_r;
  logic signed [31:0] p0x_r, p0y_r, p0z_r, p1x_r, p1y_r, p1z_r;
  logic signed [31:0] t0u_r, t0v_r, t1u_r, t1v_r;
  logic               out_valid_r;
  logic [1:0]         slot_r;
  result_t            out_r;

  logic    in_acc;
  logic    out_acc;
  logic    start;
  delta_t  delta;
  logic    res_valid;
  result_t res;

  // handshake
  assign in_stall = busy_r;
  assign in_acc   = in_valid && !busy_r;
  assign out_acc  = out_valid_r && !out_stall;
  assign start    = in_acc && (corner_cnt_r == CLOSING_CORNER);

  // edge and uv deltas against the first corner
  always_comb begin
    delta.dp1_x = 33'(p1x_r) - 33'(p0x_r);
    delta.dp1_y = 33'(p1y_r) - 33'(p0y_r);
    delta.dp1_z = 33'(p1z_r) - 33'(p0z_r);
    delta.dp2_x = 33'(in_pos_x) - 33'(p0x_r);
    delta.dp2_y = 33'(in_pos_y) - 33'(p0y_r);
    delta.dp2_z = 33'(in_pos_z) - 33'(p0z_r);
    delta.du1   = 33'(t1u_r) - 33'(t0u_r);
    delta.dv1   = 33'(t1v_r) - 33'(t0v_r);
    delta.du2   = 33'(in_tex_u) - 33'(t0u_r);
    delta.dv2   = 33'(in_tex_v) - 33'(t0v_r);
  end

  // held corners
  always_ff @(posedge clk) begin
    if (in_acc && corner_cnt_r == 2'd0) begin
      p0x_r <= in_pos_x;
      p0y_r <= in_pos_y;
      p0z_r <= in_pos_z;
      t0u_r <= in_tex_u;
      t0v_r <= in_tex_v;
    end
    if (in_acc && corner_cnt_r == 2'd1) begin
      p1x_r <= in_pos_x;
      p1y_r <= in_pos_y;
      p1z_r <= in_pos_z;
      t1u_r <= in_tex_u;
      t1v_r <= in_tex_v;
    end
  end

  // corner count and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_cnt_r <= '0;
      busy_r       <= 1'b0;
    end else begin
      if (in_acc) begin
        corner_cnt_r <= start ? 2'd0 : corner_cnt_r + 2'd1;
      end
      if (start) begin
        busy_r <= 1'b1;
      end else if (out_acc && slot_r == LAST_SLOT) begin
        busy_r <= 1'b0;
      end
    end
  end

  ttg_core #(
    .TANGENT_FRAC_BITS(TANGENT_FRAC_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .delta    (delta),
    .res_valid(res_valid),
    .res      (res)
  );

  // output word register, three copies per triangle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      slot_r      <= '0;
    end else begin
      if (res_valid) begin
        out_valid_r <= 1'b1;
        slot_r      <= '0;
      end else if (out_acc) begin
        if (slot_r == LAST_SLOT) begin
          out_valid_r <= 1'b0;
        end else begin
          slot_r <= slot_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_tangent_x        = out_r.tangent_x;
  assign out_tangent_y        = out_r.tangent_y;
  assign out_tangent_z        = out_r.tangent_z;
  assign out_corner_slot      = slot_r;
  assign out_last_of_triangle = (slot_r == LAST_SLOT);
  assign out_uv_degenerate    = out_r.uv_degenerate;
  assign out_zero_tangent     = out_r.zero_tangent;

  // words are only shown while a triangle is in flight
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> busy_r)
    else $error("output word without a triangle in flight");

  // the core never finishes over a pending word
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !out_valid_r)
    else $error("result overwrites a pending word");

  // slot stays within the three corners
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (slot_r <= LAST_SLOT))
    else $error("corner slot out of range");

  // the corner count never passes the closing corner
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    corner_cnt_r <= CLOSING_CORNER)
    else $error("corner count out of range");

endmodule

### tb/tb.sv
// self-checking testbench for the triangle tangent generator
`timescale 1ns / 100ps

module tb;
  import ttg_pkg::*;

  localparam int FRAC = TANGENT_FRAC_BITS_DEF;
  localparam int N_DIRECTED = 21;
  localparam int N_RANDOM = 249;
  localparam int MAX_WAIT = 18;

  // one tangent word as it leaves the block
  typedef struct packed {
    logic [31:0] tx;
    logic [31:0] ty;
    logic [31:0] tz;
    logic [1:0]  slot;
    logic        last;
    logic        degen;
    logic        zero;
  } tangent_word_t;

  // one vertex, with the first word of its triangle typed in when known
  typedef struct packed {
    logic [31:0]   px;
    logic [31:0]   py;
    logic [31:0]   pz;
    logic [31:0]   tu;
    logic [31:0]   tv;
    logic          known;
    tangent_word_t fixed;
  } vertex_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [31:0] in_pos_x, in_pos_y, in_pos_z, in_tex_u, in_tex_v;
  logic out_valid;
  logic out_stall;
  logic signed [31:0] out_tangent_x, out_tangent_y, out_tangent_z;
  logic [1:0] out_corner_slot;
  logic out_last_of_triangle, out_uv_degenerate, out_zero_tangent;

  triangle_tangent_generator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_tex_u(in_tex_u), .in_tex_v(in_tex_v),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_tangent_x(out_tangent_x), .out_tangent_y(out_tangent_y),
    .out_tangent_z(out_tangent_z), .out_corner_slot(out_corner_slot),
    .out_last_of_triangle(out_last_of_triangle),
    .out_uv_degenerate(out_uv_degenerate), .out_zero_tangent(out_zero_tangent)
  );

  tangent_word_t expected_tangents[$];
  vertex_row_t   vertex_table[N_DIRECTED];
  logic [31:0]   corner_pos[2][3];
  logic [31:0]   corner_uv[2][2];
  int            corners_held;
  int            n_errors;
  bit            stim_done;
  bit            hold_off;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // a*b - c*d as signed 68-bit
  function automatic logic signed [67:0] cross_diff(logic signed [33:0] a,
      logic signed [33:0] b, logic signed [33:0] c, logic signed [33:0] d);
    logic signed [67:0] p, q;
    p = 68'(a) * 68'(b);
    q = 68'(c) * 68'(d);
    return p - q;
  endfunction

  // tangent of the triangle closed by this vertex
  function automatic tangent_word_t triangle_tangent(logic [31:0] p2[3],
      logic [31:0] u2, logic [31:0] v2);
    logic signed [33:0] dp1[3], dp2[3];
    logic signed [33:0] du1, dv1, du2, dv2;
    logic signed [67:0] det;
    logic signed [67:0] t[3];
    logic [67:0] mag[3];
    logic [63:0] m[3];
    logic [63:0] sum, len, rem, rbit, q;
    int maxb, sh;
    tangent_word_t w;
    for (int i = 0; i < 3; i++) begin
      dp1[i] = 34'($signed(corner_pos[1][i])) - 34'($signed(corner_pos[0][i]));
      dp2[i] = 34'($signed(p2[i])) - 34'($signed(corner_pos[0][i]));
    end
    du1 = 34'($signed(corner_uv[1][0])) - 34'($signed(corner_uv[0][0]));
    dv1 = 34'($signed(corner_uv[1][1])) - 34'($signed(corner_uv[0][1]));
    du2 = 34'($signed(u2)) - 34'($signed(corner_uv[0][0]));
    dv2 = 34'($signed(v2)) - 34'($signed(corner_uv[0][1]));
    det = cross_diff(du1, dv2, dv1, du2);
    w = '0;
    w.degen = (det == 0);
    maxb = 0;
    for (int i = 0; i < 3; i++) begin
      t[i] = cross_diff(dp1[i], dv2, dp2[i], dv1);
      if (det < 0) t[i] = -t[i];
      mag[i] = t[i] < 0 ? 68'(-t[i]) : 68'(t[i]);
      for (int k = 0; k < 68; k++) if (mag[i][k] && k + 1 > maxb) maxb = k + 1;
    end
    w.zero = (maxb == 0);
    if (!w.zero) begin
      sh = maxb > 31 ? maxb - 31 : 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = 64'(mag[i] >> sh);
        sum += m[i] * m[i];
      end
      // bitwise integer square root
      len = 0;
      rem = sum;
      rbit = 64'd1 << 62;
      while (rbit > rem) rbit >>= 2;
      while (rbit != 0) begin
        if (rem >= len + rbit) begin
          rem -= len + rbit;
          len = (len >> 1) + rbit;
        end else begin
          len >>= 1;
        end
        rbit >>= 2;
      end
      if (len == 0) len = 1;
      q = (m[0] << FRAC) / len; w.tx = t[0] < 0 ? 32'(-q) : 32'(q);
      q = (m[1] << FRAC) / len; w.ty = t[1] < 0 ? 32'(-q) : 32'(q);
      q = (m[2] << FRAC) / len; w.tz = t[2] < 0 ? 32'(-q) : 32'(q);
    end
    return w;
  endfunction

  // append one expected word
  function automatic void queue_word(tangent_word_t w);
    expected_tangents = {expected_tangents, w};
  endfunction

  // track corners and queue three words per closed triangle
  function automatic void take_vertex(vertex_row_t r);
    logic [31:0] p[3];
    tangent_word_t w;
    p = '{r.px, r.py, r.pz};
    if (corners_held < 2) begin
      corner_pos[corners_held] = p;
      corner_uv[corners_held] = '{r.tu, r.tv};
      corners_held++;
      return;
    end
    corners_held = 0;
    w = triangle_tangent(p, r.tu, r.tv);
    if (r.known && w != r.fixed) begin
      $display("%0t: typed-in row disagrees exp %h act %h", $time, r.fixed, w);
      n_errors++;
    end
    for (int k = 0; k < 3; k++) begin
      w.slot = 2'(k);
      w.last = (2'(k) == LAST_SLOT);
      queue_word(w);
    end
  endfunction

  function automatic vertex_row_t row(logic [31:0] px, logic [31:0] py,
      logic [31:0] pz, logic [31:0] tu, logic [31:0] tv);
    vertex_row_t r;
    r = '0;
    r.px = px; r.py = py; r.pz = pz; r.tu = tu; r.tv = tv;
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2: return 32'($signed($urandom_range(0, 16)) - 8);
      default: return 32'($signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000);
    endcase
  endfunction

  task automatic send_vertex(vertex_row_t r);
    int idle_cycles;
    idle_cycles = $urandom_range(0, 3) == 0 ? $urandom_range(0, MAX_WAIT) : 0;
    if (idle_cycles > 0) begin
      in_valid <= 1'b0;
      repeat (idle_cycles) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= r.px; in_pos_y <= r.py; in_pos_z <= r.pz;
    in_tex_u <= r.tu; in_tex_v <= r.tv;
    do @(posedge clk); while (in_stall);
    take_vertex(r);
  endtask

  // stimulus
  initial begin
    vertex_row_t r;
    in_valid = 1'b0; out_stall = 1'b0;
    in_pos_x = '0; in_pos_y = '0; in_pos_z = '0; in_tex_u = '0; in_tex_v = '0;
    rst_n = 1'b0; n_errors = 0; corners_held = 0; stim_done = 0; hold_off = 0;
    // unit tangent along x: uv aligned with x and y
    vertex_table[0] = row(0, 0, 0, 0, 0);
    vertex_table[1] = row(32'h10000, 0, 0, 32'h10000, 0);
    vertex_table[2] = row(0, 32'h10000, 0, 0, 32'h10000);
    vertex_table[2].known = 1;
    vertex_table[2].fixed = '{32'h40000000, 0, 0, 0, 0, 0, 0};
    // zero tangent and zero determinant together: all uv equal
    vertex_table[3] = row(1, 2, 3, 5, 5);
    vertex_table[4] = row(7, 8, 9, 5, 5);
    vertex_table[5] = row(4, 4, 4, 5, 5);
    vertex_table[5].known = 1;
    vertex_table[5].fixed = '{0, 0, 0, 0, 0, 1, 1};
    // negative determinant flips the tangent: mirrored u
    vertex_table[6] = row(0, 0, 0, 0, 0);
    vertex_table[7] = row(32'h10000, 0, 0, 32'hffff0000, 0);
    vertex_table[8] = row(0, 32'h10000, 0, 0, 32'h10000);
    vertex_table[8].known = 1;
    vertex_table[8].fixed = '{32'hc0000000, 0, 0, 0, 0, 0, 0};
    // extremes of every field
    vertex_table[9]  = row(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
    vertex_table[10] = row(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    vertex_table[11] = row(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    vertex_table[12] = row(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h80000000);
    vertex_table[13] = row(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    vertex_table[14] = row(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000);
    // degenerate uv with a real tangent: collinear uv
    vertex_table[15] = row(0, 0, 0, 0, 0);
    vertex_table[16] = row(32'h30000, 32'h10000, 0, 32'h10000, 32'h10000);
    vertex_table[17] = row(0, 32'h50000, 32'h20000, 32'h20000, 32'h20000);
    // tiny values
    vertex_table[18] = row(0, 0, 0, 0, 0);
    vertex_table[19] = row(1, 0, 0, 1, 0);
    vertex_table[20] = row(0, 1, 1, 0, 1);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (vertex_table[i]) send_vertex(vertex_table[i]);
    for (int n = 0; n < N_RANDOM; n++) begin
      r = '0;
      r.px = rand_coord(); r.py = rand_coord(); r.pz = rand_coord();
      r.tu = rand_coord(); r.tv = rand_coord();
      // occasionally repeat the first held corner's uv to hit zero uv deltas
      if ($urandom_range(0, 15) == 0 && corners_held > 0) begin
        r.tu = corner_uv[0][0]; r.tv = corner_uv[0][1];
      end
      if (n == 60) hold_off = 1;
      send_vertex(r);
    end
    in_valid <= 1'b0;
    stim_done = 1;
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        hold_off = 0;
        out_stall <= 1'b1;
        repeat (1500) @(posedge clk);
      end
      gap = $urandom_range(0, 2) == 0 ? $urandom_range(0, MAX_WAIT) : 0;
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  // result checking
  always @(posedge clk) begin
    tangent_word_t act, exp_w;
    if (rst_n && out_valid && !out_stall) begin
      act = '{out_tangent_x, out_tangent_y, out_tangent_z, out_corner_slot,
              out_last_of_triangle, out_uv_degenerate, out_zero_tangent};
      if (expected_tangents.size() == 0) begin
        $display("%0t: unexpected word exp none act %h", $time, act);
        n_errors++;
      end else begin
        exp_w = expected_tangents.pop_front();
        if (act.tx !== exp_w.tx || act.ty !== exp_w.ty || act.tz !== exp_w.tz ||
            act.slot !== exp_w.slot || act.last !== exp_w.last ||
            act.degen !== exp_w.degen || act.zero !== exp_w.zero) begin
          $display("%0t: mismatch exp %h act %h", $time, exp_w, act);
          n_errors++;
        end
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    wait (expected_tangents.size() == 0);
    repeat (300) @(posedge clk);
    if (n_errors == 0 && expected_tangents.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // timeout
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

### files.f
hdl/ttg_pkg.sv
hdl/ttg_core.sv
hdl/triangle_tangent_generator.sv
tb/tb.sv
